// File: hw/rtl/pvi_pkg.sv
// Shared types, constants and the saturation helper for the planar velocity integrator.
// Used by pvi_lane, pvi_merge and planar_velocity_integrator_top.
package pvi_pkg;

	localparam int OP_W    = 33;
	localparam int MB_W    = 18;
	localparam int PROD_W  = 51;
	localparam int DT_FRAC   = 16;
	localparam int FRIC_FRAC = 16;

	localparam logic [16:0] FRIC_ONE   = 17'd65536;
	localparam logic [16:0] FRIC_RESET = 17'd64225;

	localparam logic signed [PROD_W-1:0] S32_MAX = $signed({{(PROD_W-31){1'b0}}, {31{1'b1}}});
	localparam logic signed [PROD_W-1:0] S32_MIN = $signed({{(PROD_W-31){1'b1}}, 31'h0});

	typedef enum logic [2:0] {
		CMD_UPDATE    = 3'd0,
		CMD_TRANSLATE = 3'd1,
		CMD_END_FRAME = 3'd2,
		CMD_ADD_ACCEL = 3'd3,
		CMD_SET_ACCEL = 3'd4,
		CMD_SET_VEL   = 3'd5
	} cmd_e;

	typedef enum logic [1:0] {
		REG_FRICTION = 2'd0,
		REG_CLAMP_EN = 2'd1,
		REG_MAX_X    = 2'd2,
		REG_MAX_Y    = 2'd3
	} cfg_idx_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_MUL1,
		ST_RND,
		ST_ADD,
		ST_MUL2,
		ST_FIN,
		ST_DONE
	} state_e;

	typedef struct packed {
		logic [2:0]         command;
		logic [15:0]        delta_time;
		logic signed [31:0] operand_x;
		logic signed [31:0] operand_y;
		logic               write_x;
		logic               write_y;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic               saturated;
	} out_item_t;

	typedef struct packed {
		state_e      st;
		logic        start;
		cmd_e        cmd;
		logic [15:0] dt;
		logic [16:0] fric;
		logic        clamp_en;
	} lane_ctrl_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               sat;
	} lane_res_t;

	// {overflow, value}
	function automatic logic [32:0] sat32(input logic signed [PROD_W-1:0] x);
		logic [32:0] r;
		if (x > S32_MAX)
			r = {1'b1, 1'b0, {31{1'b1}}};
		else if (x < S32_MIN)
			r = {1'b1, 1'b1, 31'h0};
		else
			r = {1'b0, x[31:0]};
		return r;
	endfunction

endpackage

// File: hw/rtl/pvi_lane.sv
// One axis lane: holds that axis's velocity, prior velocity and acceleration and
// steps them through a shared multiply-round-saturate datapath. Depends on pvi_pkg.
module pvi_lane import pvi_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lane_ctrl_t         ctrl,
	input  logic signed [31:0] operand,
	input  logic               wr,
	input  logic [30:0]        max_speed,
	output lane_res_t          res
);

	localparam logic [32:0] UNIT = 33'(1) << FRAC_BITS;

	logic signed [31:0]     v_q, vo_q, a_q, op_q, d_q, nv_q;
	logic signed [OP_W-1:0] opnd_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                   sat_q;

	logic signed [OP_W-1:0]   ma;
	logic signed [MB_W-1:0]   mb;
	logic signed [PROD_W-1:0] mul_full, rnd, shifted, add_ext;
	logic signed [OP_W-1:0]   sum33;
	logic signed [31:0]       base;
	logic signed [31:0]       addend;
	logic [32:0]              s_out;
	logic [32:0]              mag;
	logic signed [31:0]       fin_v;
	logic                     clamp_hit;

	always_comb begin
		if (ctrl.st == ST_MUL2) begin
			ma  = OP_W'(nv_q);
			mb  = $signed({1'b0, ctrl.fric});
			rnd = PROD_W'(1) << (FRIC_FRAC - 1);
		end else begin
			ma  = opnd_q;
			mb  = $signed({2'b0, ctrl.dt});
			rnd = (ctrl.cmd == CMD_TRANSLATE) ? PROD_W'(1) << DT_FRAC
				: PROD_W'(1) << (DT_FRAC - 1);
		end
	end

	assign mul_full = ma * mb;

	// PRE adds the acceleration operand, ADD adds the rounded product
	always_comb begin
		if (ctrl.st == ST_PRE) begin
			base   = a_q;
			addend = op_q;
		end else begin
			base   = (ctrl.cmd == CMD_TRANSLATE) ? op_q : v_q;
			addend = d_q;
		end
		sum33   = OP_W'(base) + OP_W'(addend);
		add_ext = PROD_W'(sum33);
		if (ctrl.st == ST_RND && ctrl.cmd == CMD_TRANSLATE)
			shifted = prod_q >>> (DT_FRAC + 1);
		else if (ctrl.st == ST_RND)
			shifted = prod_q >>> DT_FRAC;
		else
			shifted = prod_q >>> FRIC_FRAC;
		if (ctrl.st == ST_PRE || ctrl.st == ST_ADD)
			s_out = sat32(add_ext);
		else
			s_out = sat32(shifted);
	end

	// damping result: small-speed zeroing first, then the speed limit
	always_comb begin
		mag       = s_out[31] ? (33'd0 - {1'b1, s_out[31:0]}) : {1'b0, s_out[31:0]};
		fin_v     = s_out[31:0];
		clamp_hit = 1'b0;
		if (mag < UNIT) begin
			fin_v = '0;
		end else if (ctrl.clamp_en && mag > {2'b0, max_speed}) begin
			clamp_hit = 1'b1;
			fin_v     = s_out[31] ? 32'(33'd0 - {2'b0, max_speed}) : {1'b0, max_speed};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= '0;
			vo_q  <= '0;
			a_q   <= '0;
			sat_q <= 1'b0;
		end else begin
			if (ctrl.start) begin
				sat_q <= 1'b0;
			end
			unique case (ctrl.st)
				ST_PRE: begin
					unique case (ctrl.cmd)
						CMD_END_FRAME: vo_q <= v_q;
						CMD_ADD_ACCEL: begin
							a_q   <= s_out[31:0];
							sat_q <= sat_q | s_out[32];
						end
						CMD_SET_ACCEL: if (wr) a_q <= op_q;
						CMD_SET_VEL:   v_q <= op_q;
						default: ;
					endcase
				end
				ST_RND: sat_q <= sat_q | s_out[32];
				ST_ADD: sat_q <= sat_q | s_out[32];
				ST_FIN: begin
					sat_q <= sat_q | s_out[32];
					v_q   <= fin_v;
					if (clamp_hit) a_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			op_q <= operand;
		end
		if (ctrl.st == ST_PRE) begin
			opnd_q <= (ctrl.cmd == CMD_TRANSLATE) ? OP_W'(vo_q) + OP_W'(v_q) : OP_W'(a_q);
		end
		if (ctrl.st == ST_MUL1 || ctrl.st == ST_MUL2) begin
			prod_q <= mul_full + rnd;
		end
		if (ctrl.st == ST_RND) begin
			d_q <= s_out[31:0];
		end
		if (ctrl.st == ST_ADD) begin
			nv_q <= s_out[31:0];
		end
	end

	assign res.value = (ctrl.cmd == CMD_TRANSLATE) ? nv_q : v_q;
	assign res.sat   = sat_q;

endmodule

// File: hw/rtl/pvi_merge.sv
// Output stage: merges the two lane results into one result transaction and
// holds it until taken. Depends on pvi_pkg.
module pvi_merge import pvi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  lane_res_t lane_x,
	input  lane_res_t lane_y,
	output logic      free,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	logic      valid_q;
	out_item_t data_q;

	assign free         = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign result       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q.out_x     <= lane_x.value;
			data_q.out_y     <= lane_y.value;
			data_q.saturated <= lane_x.sat | lane_y.sat;
		end
	end

endmodule

// File: hw/rtl/planar_velocity_integrator_top.sv
// 2-D velocity integrator: one lane per axis under a shared sequencer, plus the
// configuration registers and the output stage. Depends on pvi_pkg, pvi_lane, pvi_merge.
//
// One transaction in, one result out. Update velocity steps through PRE, MUL1, RND,
// ADD, MUL2 and FIN before DONE (two passes through each lane's multiplier, each
// followed by round and saturate); translate point steps through PRE, MUL1, RND and
// ADD before DONE (one multiplier pass plus the point add); the other commands go
// from PRE straight to DONE. A new transaction is accepted the cycle after the previous
// result is handed to the output register, which holds it until taken; while it is not
// taken the next result waits and no input is accepted.
// Configuration writes take effect at once and are expected only while idle.
module planar_velocity_integrator_top import pvi_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  in_item_t    item,
	output logic        result_valid,
	input  logic        result_ready,
	output out_item_t   result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data
);

	state_e      state_q, state_d;
	cmd_e        cmd_q;
	logic [15:0] dt_q;
	logic        wx_q, wy_q;
	logic [16:0] fric_q;
	logic        clamp_q;
	logic [30:0] maxx_q, maxy_q;

	logic       start, load, free;
	lane_ctrl_t ctrl;
	lane_res_t  res_x, res_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		load       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) state_d = ST_PRE;
			end
			ST_PRE: begin
				if (cmd_q == CMD_UPDATE || cmd_q == CMD_TRANSLATE)
					state_d = ST_MUL1;
				else
					state_d = ST_DONE;
			end
			ST_MUL1: state_d = ST_RND;
			ST_RND:  state_d = ST_ADD;
			ST_ADD:  state_d = (cmd_q == CMD_TRANSLATE) ? ST_DONE : ST_MUL2;
			ST_MUL2: state_d = ST_FIN;
			ST_FIN:  state_d = ST_DONE;
			ST_DONE: begin
				load = free;
				if (free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign start = item_valid && item_ready;

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q <= cmd_e'(item.command);
			dt_q  <= item.delta_time;
			wx_q  <= item.write_x;
			wy_q  <= item.write_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fric_q  <= FRIC_RESET;
			clamp_q <= 1'b0;
			maxx_q  <= '0;
			maxy_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_e'(cfg_index))
				REG_FRICTION: fric_q  <= cfg_data[16:0];
				REG_CLAMP_EN: clamp_q <= cfg_data[0];
				REG_MAX_X:    maxx_q  <= cfg_data;
				REG_MAX_Y:    maxy_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		ctrl.st       = state_q;
		ctrl.start    = start;
		ctrl.cmd      = cmd_q;
		ctrl.dt       = dt_q;
		ctrl.fric     = (fric_q > FRIC_ONE) ? FRIC_ONE : fric_q;
		ctrl.clamp_en = clamp_q;
	end

	pvi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.operand   (item.operand_x),
		.wr        (wx_q),
		.max_speed (maxx_q),
		.res       (res_x)
	);

	pvi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.operand   (item.operand_y),
		.wr        (wy_q),
		.max_speed (maxy_q),
		.res       (res_y)
	);

	pvi_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.lane_x       (res_x),
		.lane_y       (res_y),
		.free         (free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
